FILE: rtl/core/assert_macros.svh
// Assertion helpers; clock and reset names are fixed to the house names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that cond on one edge forces nxt on the next edge.
`define ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

FILE: rtl/core/ccd_pkg.sv
package ccd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int NUM_W  = 44;
    localparam int DEN_W  = 28;
    localparam int Q_W    = 16;
    localparam int DIV_ITERS = Q_W / 2;

    typedef enum logic [2:0] {
        REG_START_TIME = 3'd0,
        REG_CUR_LOW    = 3'd1,
        REG_CUR_HIGH   = 3'd2,
        REG_CELL_START = 3'd3,
        REG_CELL_CUT   = 3'd4,
        REG_BRD_START  = 3'd5,
        REG_BRD_CUT    = 3'd6,
        REG_RAMP_TIME  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2,
        MODE_RSVD = 2'd3
    } t_mode;

    typedef struct packed {
        logic        [31:0] start_time_ms;
        logic        [15:0] current_low_line_ma;
        logic        [15:0] current_high_line_ma;
        logic signed [11:0] cell_derate_start;
        logic signed [11:0] cell_cutoff_temp;
        logic signed [11:0] board_derate_start;
        logic signed [11:0] board_cutoff_temp;
        logic        [15:0] ramp_time_ms;
    } t_cfg;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_work;

    typedef struct packed {
        logic push;
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: rtl/core/ccd_front.sv
module ccd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccd_pkg::t_cfg       i_cfg,
    input  logic                i_accept,
    input  logic [31:0]         i_time_ms,
    input  logic [12:0]         i_max_cell_mv,
    input  logic [13:0]         i_pack_voltage,
    input  logic [13:0]         i_pack_limit,
    input  logic [12:0]         i_cell_limit_mv,
    input  logic [1:0]          i_charger_mode,
    input  logic                i_shutdown_ok,
    input  logic                i_bms_charging,
    input  logic signed [11:0]  i_cell_temp,
    input  logic signed [11:0]  i_board_temp,
    output logic                o_push,
    output ccd_pkg::t_work      o_work
);
    import ccd_pkg::*;

    // Stage 1: gate, base, ramp and temperature fractions.
    logic        r_v1, r_ok1;
    logic [15:0] r_base1, r_rn1, r_rd1;
    logic [11:0] r_cn1, r_cd1, r_bn1, r_bd1;
    // Stage 2: compare fractions, base * ramp numerator.
    logic        r_v2, r_ok2, r_cell2;
    logic [31:0] r_p2;
    logic [15:0] r_rd2;
    logic [11:0] r_cn2, r_cd2, r_bn2, r_bd2;
    // Stage 3: final numerator and denominator.
    logic             r_v3;
    logic [NUM_W-1:0] r_num3;
    logic [DEN_W-1:0] r_den3;

    logic        n_ok, n_ramp;
    logic [31:0] n_elapsed;
    logic [11:0] n_cn, n_cd, n_bn, n_bd;
    logic signed [12:0] n_cdiff_t, n_cdiff_s, n_bdiff_t, n_bdiff_s;
    logic [11:0] n_tn, n_td;

    always_comb begin
        n_ok = i_shutdown_ok && i_bms_charging
            && (i_charger_mode == MODE_LOW || i_charger_mode == MODE_HIGH)
            && (i_max_cell_mv < i_cell_limit_mv)
            && (i_pack_voltage <= i_pack_limit);
        n_elapsed = i_time_ms - i_cfg.start_time_ms;
        n_ramp    = n_elapsed < {16'd0, i_cfg.ramp_time_ms};
        n_cdiff_t = 13'(i_cfg.cell_cutoff_temp) - 13'(i_cell_temp);
        n_cdiff_s = 13'(i_cfg.cell_cutoff_temp) - 13'(i_cfg.cell_derate_start);
        n_bdiff_t = 13'(i_cfg.board_cutoff_temp) - 13'(i_board_temp);
        n_bdiff_s = 13'(i_cfg.board_cutoff_temp) - 13'(i_cfg.board_derate_start);
        if (i_cell_temp < i_cfg.cell_derate_start) begin
            n_cn = 12'd1; n_cd = 12'd1;
        end else if (i_cell_temp >= i_cfg.cell_cutoff_temp) begin
            n_cn = 12'd0; n_cd = 12'd1;
        end else begin
            n_cn = n_cdiff_t[11:0]; n_cd = n_cdiff_s[11:0];
        end
        if (i_board_temp < i_cfg.board_derate_start) begin
            n_bn = 12'd1; n_bd = 12'd1;
        end else if (i_board_temp >= i_cfg.board_cutoff_temp) begin
            n_bn = 12'd0; n_bd = 12'd1;
        end else begin
            n_bn = n_bdiff_t[11:0]; n_bd = n_bdiff_s[11:0];
        end
        n_tn = r_cell2 ? r_cn2 : r_bn2;
        n_td = r_cell2 ? r_cd2 : r_bd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok1   <= n_ok;
        r_base1 <= (i_charger_mode == MODE_LOW) ? i_cfg.current_low_line_ma
                                                : i_cfg.current_high_line_ma;
        r_rn1   <= n_ramp ? n_elapsed[15:0] : 16'd1;
        r_rd1   <= n_ramp ? i_cfg.ramp_time_ms : 16'd1;
        r_cn1   <= n_cn;
        r_cd1   <= n_cd;
        r_bn1   <= n_bn;
        r_bd1   <= n_bd;

        r_ok2   <= r_ok1;
        r_cell2 <= (24'(r_cn1) * 24'(r_bd1)) <= (24'(r_bn1) * 24'(r_cd1));
        r_p2    <= 32'(r_base1) * 32'(r_rn1);
        r_rd2   <= r_rd1;
        r_cn2   <= r_cn1;
        r_cd2   <= r_cd1;
        r_bn2   <= r_bn1;
        r_bd2   <= r_bd1;

        r_num3  <= r_ok2 ? NUM_W'(r_p2) * NUM_W'(n_tn) : '0;
        r_den3  <= r_ok2 ? DEN_W'(r_rd2) * DEN_W'(n_td) : DEN_W'(1);
    end

    assign o_push      = r_v3;
    assign o_work.num  = r_num3;
    assign o_work.den  = r_den3;

endmodule

FILE: rtl/core/ccd_queue.sv
module ccd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ccd_pkg::t_work  i_work,
    input  logic            i_pop,
    output ccd_pkg::t_work  o_work,
    output ccd_pkg::t_qstat o_stat
);
    import ccd_pkg::*;

    t_work          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_work;
    end

    assign o_work       = r_mem[r_rp];
    assign o_stat.push  = i_push;
    assign o_stat.full  = r_cnt == (QAW+1)'(QDEPTH);
    assign o_stat.empty = r_cnt == '0;

endmodule

FILE: rtl/core/ccd_divider.sv
module ccd_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ccd_pkg::t_work i_work,
    output logic           o_pop,
    output logic           o_valid,
    output logic [15:0]    o_quot
);
    import ccd_pkg::*;

    logic             r_run, r_valid;
    logic [2:0]       r_cnt;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [Q_W-1:0]   r_low, r_q;

    logic [DEN_W:0]   n_t1, n_t2;
    logic [DEN_W-1:0] n_r1, n_r2;
    logic             n_q1, n_q2;

    // Two restoring steps per cycle while a division runs.
    always_comb begin
        n_t1 = {r_rem, r_low[Q_W-1]};
        n_q1 = n_t1 >= {1'b0, r_den};
        n_r1 = n_q1 ? DEN_W'(n_t1 - {1'b0, r_den}) : n_t1[DEN_W-1:0];
        n_t2 = {n_r1, r_low[Q_W-2]};
        n_q2 = n_t2 >= {1'b0, r_den};
        n_r2 = n_q2 ? DEN_W'(n_t2 - {1'b0, r_den}) : n_t2[DEN_W-1:0];
    end

    assign o_pop = !r_run && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= r_run && (r_cnt == 3'(DIV_ITERS - 1));
            if (o_pop) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 3'(DIV_ITERS - 1)) r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem <= i_work.num[NUM_W-1:Q_W];
            r_low <= i_work.num[Q_W-1:0];
            r_den <= i_work.den;
        end else if (r_run) begin
            r_rem <= n_r2;
            r_low <= {r_low[Q_W-3:0], 2'b00};
            r_q   <= {r_q[Q_W-3:0], n_q1, n_q2};
        end
    end

    assign o_valid = r_valid;
    assign o_quot  = r_q;

endmodule

FILE: rtl/core/charge_current_derate_top.sv
// Charge current derate: permitted charger current in mA from one snapshot.
// Command channel: drive the snapshot fields and raise start; the item is
// taken at an edge where start is high and busy is low. busy rises only when
// four items are in flight ahead of the divider.
// Result channel: o_valid pulses for one cycle with o_charge_current_ma.
// The receiver cannot stall; every result is shown exactly once.
// Pipeline: three front stages (gate and fractions, fraction compare and
// ramp product, final product), a queue, then a radix-4 divider that
// works on one item at a time and takes the next only when it is done.
// Configuration: APB writes at byte address 4*index, reads return the value.
// Write registers only while no item is in flight.
// Reset (synchronous, active low) empties the pipeline and the queue and
// loads every register with its default.
module charge_current_derate_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_time_ms,
    input  logic [12:0]        i_max_cell_mv,
    input  logic [13:0]        i_pack_voltage,
    input  logic [13:0]        i_pack_limit,
    input  logic [12:0]        i_cell_limit_mv,
    input  logic [1:0]         i_charger_mode,
    input  logic               i_shutdown_ok,
    input  logic               i_bms_charging,
    input  logic signed [11:0] i_cell_temp,
    input  logic signed [11:0] i_board_temp,
    output logic               o_valid,
    output logic [15:0]        o_charge_current_ma
);
    import ccd_pkg::*;
`include "assert_macros.svh"

    t_cfg         r_cfg;
    logic [QAW:0] r_occ;
    logic         accept, push, pop;
    t_work        front_work, q_work;
    t_qstat       q_stat;
    t_reg_idx     widx;

    assign pready = 1'b1;
    assign widx   = t_reg_idx'(paddr[4:2]);

    // Register file: write on the access beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_time_ms        <= 32'd0;
            r_cfg.current_low_line_ma  <= 16'd3500;
            r_cfg.current_high_line_ma <= 16'd11000;
            r_cfg.cell_derate_start    <= 12'sd400;
            r_cfg.cell_cutoff_temp     <= 12'sd450;
            r_cfg.board_derate_start   <= 12'sd500;
            r_cfg.board_cutoff_temp    <= 12'sd600;
            r_cfg.ramp_time_ms         <= 16'd1000;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                REG_START_TIME: r_cfg.start_time_ms        <= pwdata;
                REG_CUR_LOW:    r_cfg.current_low_line_ma  <= pwdata[15:0];
                REG_CUR_HIGH:   r_cfg.current_high_line_ma <= pwdata[15:0];
                REG_CELL_START: r_cfg.cell_derate_start    <= pwdata[11:0];
                REG_CELL_CUT:   r_cfg.cell_cutoff_temp     <= pwdata[11:0];
                REG_BRD_START:  r_cfg.board_derate_start   <= pwdata[11:0];
                REG_BRD_CUT:    r_cfg.board_cutoff_temp    <= pwdata[11:0];
                REG_RAMP_TIME:  r_cfg.ramp_time_ms         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Readback, sign-extend the temperature registers.
    always_comb begin
        unique case (widx)
            REG_START_TIME: prdata = r_cfg.start_time_ms;
            REG_CUR_LOW:    prdata = {16'd0, r_cfg.current_low_line_ma};
            REG_CUR_HIGH:   prdata = {16'd0, r_cfg.current_high_line_ma};
            REG_CELL_START: prdata = 32'(r_cfg.cell_derate_start);
            REG_CELL_CUT:   prdata = 32'(r_cfg.cell_cutoff_temp);
            REG_BRD_START:  prdata = 32'(r_cfg.board_derate_start);
            REG_BRD_CUT:    prdata = 32'(r_cfg.board_cutoff_temp);
            REG_RAMP_TIME:  prdata = {16'd0, r_cfg.ramp_time_ms};
            default:        prdata = 32'd0;
        endcase
    end

    // Credit count: items in the front stages plus the queue. Hold busy
    // when every queue slot is spoken for, so the front never has to stall.
    assign busy   = r_occ == (QAW+1)'(QDEPTH);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + (QAW+1)'(accept) - (QAW+1)'(pop);
        end
    end

    ccd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_accept        (accept),
        .i_time_ms       (i_time_ms),
        .i_max_cell_mv   (i_max_cell_mv),
        .i_pack_voltage  (i_pack_voltage),
        .i_pack_limit    (i_pack_limit),
        .i_cell_limit_mv (i_cell_limit_mv),
        .i_charger_mode  (i_charger_mode),
        .i_shutdown_ok   (i_shutdown_ok),
        .i_bms_charging  (i_bms_charging),
        .i_cell_temp     (i_cell_temp),
        .i_board_temp    (i_board_temp),
        .o_push          (push),
        .o_work          (front_work)
    );

    ccd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .i_pop   (pop),
        .o_work  (q_work),
        .o_stat  (q_stat)
    );

    // Advance one beat from the queue into the divider whenever it is free and the queue is not empty.
    ccd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_stat.empty),
        .i_work  (q_work),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_quot  (o_charge_current_ma)
    );

    `ASSERT_ALWAYS(a_occ_bound, r_occ <= (QAW+1)'(QDEPTH), "credit count overflow")
    `ASSERT_ALWAYS(a_no_push_full, !(q_stat.push && q_stat.full && !pop), "push into full queue")
    `ASSERT_NEXT(a_strobe_gap, o_valid, !o_valid, "result strobes back to back")
    `ASSERT_ALWAYS(a_pop_nonempty, !(pop && q_stat.empty), "pop from empty queue")

endmodule
